[rtl/core/nested_tlv_serializer_assert.svh]
// Assertion macros shared by the serializer RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef NESTED_TLV_SERIALIZER_ASSERT_SVH
`define NESTED_TLV_SERIALIZER_ASSERT_SVH
`ifndef SYNTH
// Check outside reset.
`define NTS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nested_tlv_serializer: assertion failed");
// Check at every edge, reset included.
`define NTS_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("nested_tlv_serializer: assertion failed");
`else
`define NTS_ASSERT(name, prop)
`define NTS_ASSERT_NR(name, prop)
`endif
`endif

[rtl/core/nts_pkg.sv]
// Shared types and constants of the nested TLV serializer.
// No dependencies.
package nts_pkg;

  localparam int ID_W       = 16;
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int OUT_ADDR_W = 16;
  localparam int CFG_W      = 16;
  localparam int MODE_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SIMPLE = 3'd0,
    MODE_DATA   = 3'd1,
    MODE_OPEN   = 3'd2,
    MODE_CLOSE  = 3'd3,
    MODE_RESET  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_DATA = 2'd3
  } status_e;

  // One job for the back end: a single word or a whole header.
  typedef struct packed {
    logic              hdr;
    logic [BYTE_W-1:0] data;
    logic              wen;
    status_e           status;
    logic [ID_W-1:0]   tag;
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

[rtl/core/nts_front.sv]
// Front end: accepts commands, keeps nesting stack and write offset, emits jobs.
// Depends on nts_pkg and nested_tlv_serializer_assert.svh.
`include "nested_tlv_serializer_assert.svh"

module nts_front import nts_pkg::*; #(
  parameter int NEST_DEPTH   = 8,
  parameter int HEADER_BYTES = 4,
  parameter int ADDR_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [ID_W-1:0]      item_id_i,
  input  logic [LEN_W-1:0]     item_len_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic [CFG_W-1:0]     start_offset_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output job_t                 job_o,
  output logic [ADDR_BITS-1:0] job_addr_o
);

  localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int LVL_W = $clog2(NEST_DEPTH + 1);
  localparam logic [ADDR_BITS-1:0] HB_A = ADDR_BITS'(HEADER_BYTES);
  localparam logic [LEN_W-1:0]     HB_L = LEN_W'(HEADER_BYTES);

  typedef struct packed {
    logic [ID_W-1:0]      tag;
    logic [LEN_W-1:0]     len;
    logic [ADDR_BITS-1:0] hdr_ofs;
  } ctx_t;

  logic [LVL_W-1:0]     level_q, level_d;
  logic [ADDR_BITS-1:0] offset_q, offset_d;
  logic [LEN_W-1:0]     remain_q, remain_d;
  ctx_t                 top_q, top_d;
  ctx_t                 below_q, below_d;
  ctx_t                 rd_q;
  ctx_t                 mem_q [NEST_DEPTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_widx;
  logic [IDX_W-1:0]     rd_idx;
  logic [31:0]          start_ext;
  logic                 fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign q_push_o   = fire;
  assign start_ext  = {16'd0, start_offset_i};

  // The stack top and the entry below it live in registers; deeper entries sit
  // in the memory, whose registered read always tracks the entry below "below".
  always_comb begin
    level_d    = level_q;
    offset_d   = offset_q;
    remain_d   = remain_q;
    top_d      = top_q;
    below_d    = below_q;
    mem_we     = 1'b0;
    mem_widx   = (level_q != '0) ? IDX_W'(32'(level_q) - 32'd1) : '0;
    job_o      = '{hdr: 1'b0, data: '0, wen: 1'b0, status: ST_OK, tag: '0, len: '0};
    job_addr_o = '0;
    if (fire) begin
      case (mode_e'(mode_i))
        MODE_SIMPLE: begin
          job_o.hdr  = 1'b1;
          job_o.tag  = item_id_i;
          job_o.len  = item_len_i;
          job_addr_o = offset_q;
          offset_d   = offset_q + HB_A;
          remain_d   = item_len_i;
          if (level_q != '0) begin
            top_d.len = top_q.len + item_len_i + HB_L;
          end
        end
        MODE_DATA: begin
          if (remain_q == '0) begin
            job_o.status = ST_BAD_DATA;
          end else begin
            job_o.wen  = 1'b1;
            job_o.data = data_byte_i;
            job_addr_o = offset_q;
            offset_d   = offset_q + ADDR_BITS'(1);
            remain_d   = remain_q - LEN_W'(1);
          end
        end
        MODE_OPEN: begin
          if (32'(level_q) >= NEST_DEPTH) begin
            job_o.status = ST_FULL;
          end else begin
            mem_we   = (level_q != '0);
            below_d  = top_q;
            top_d    = '{tag: item_id_i, len: '0, hdr_ofs: offset_q};
            level_d  = level_q + LVL_W'(1);
            offset_d = offset_q + HB_A;
          end
        end
        MODE_CLOSE: begin
          if (level_q == '0) begin
            job_o.status = ST_EMPTY;
          end else begin
            level_d = level_q - LVL_W'(1);
            top_d   = below_q;
            below_d = rd_q;
            if (top_q.len == '0) begin
              // empty composite: take back the reserved header space
              offset_d = offset_q - HB_A;
            end else begin
              job_o.hdr  = 1'b1;
              job_o.tag  = top_q.tag;
              job_o.len  = top_q.len;
              job_addr_o = top_q.hdr_ofs;
              if (level_d != '0) begin
                top_d.len = below_q.len + top_q.len + HB_L;
              end
            end
          end
        end
        MODE_RESET: begin
          level_d  = '0;
          remain_d = '0;
          offset_d = start_ext[ADDR_BITS-1:0];
        end
        default: ;
      endcase
    end
    rd_idx = (32'(level_d) >= 32'd3) ? IDX_W'(32'(level_d) - 32'd3) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      offset_q <= '0;
      remain_q <= '0;
    end else begin
      level_q  <= level_d;
      offset_q <= offset_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    below_q <= below_d;
    rd_q    <= mem_q[rd_idx];
    if (mem_we) begin
      mem_q[mem_widx] <= top_q;
    end
  end

  `NTS_ASSERT(a_underflow_hold, fire && mode_i == MODE_CLOSE && level_q == '0 |=> level_q == '0)
  `NTS_ASSERT(a_stray_byte_hold, fire && mode_i == MODE_DATA && remain_q == '0 |=> $stable(offset_q))
  `NTS_ASSERT(a_level_bound, 32'(level_q) <= NEST_DEPTH)

endmodule

[rtl/core/nts_fifo.sv]
// Small job queue between front and back end.
// No package dependency.
module nts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (32'(count_q) == DEPTH);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/nts_back.sv]
// Back end: expands queued jobs into memory write words in an output register.
// Depends on nts_pkg and nested_tlv_serializer_assert.svh.
`include "nested_tlv_serializer_assert.svh"

module nts_back import nts_pkg::*; #(
  parameter int HEADER_BYTES = 4,
  parameter int ADDR_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  job_t                  head_job_i,
  input  logic [ADDR_BITS-1:0]  head_addr_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_ADDR_W-1:0] write_addr_o,
  output logic [BYTE_W-1:0]     write_data_o,
  output logic                  write_en_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  localparam int KW        = $clog2(HEADER_BYTES);
  localparam int TAG_BYTES = HEADER_BYTES / 2;

  logic                 out_valid_q;
  logic [KW-1:0]        k_q;
  logic [OUT_ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0]    data_q;
  logic                 wen_q;
  status_e              status_q;
  logic                 last_q;

  logic                 load;
  logic [KW-1:0]        k_last;
  logic                 is_last;
  logic [KW-1:0]        sub_idx;
  logic [15:0]          src;
  logic [BYTE_W-1:0]    hdr_byte;
  logic [ADDR_BITS-1:0] res_addr;
  logic [31:0]          addr_ext;
  logic [BYTE_W-1:0]    res_data;
  logic                 res_wen;
  status_e              res_status;

  always_comb begin
    load    = !q_empty_i && (!out_valid_q || out_ready_i);
    k_last  = head_job_i.hdr ? KW'(HEADER_BYTES - 1) : '0;
    is_last = (k_q == k_last);
    q_pop_o = load && is_last;

    // header: tag bytes first, then length bytes, little-endian, zero above bit 15
    if (32'(k_q) < TAG_BYTES) begin
      src     = head_job_i.tag;
      sub_idx = k_q;
    end else begin
      src     = head_job_i.len;
      sub_idx = k_q - KW'(TAG_BYTES);
    end
    if (sub_idx == '0) begin
      hdr_byte = src[7:0];
    end else if (sub_idx == KW'(1)) begin
      hdr_byte = src[15:8];
    end else begin
      hdr_byte = '0;
    end

    if (head_job_i.hdr) begin
      res_addr   = head_addr_i + ADDR_BITS'(k_q);
      res_data   = hdr_byte;
      res_wen    = 1'b1;
      res_status = ST_OK;
    end else begin
      res_addr   = head_addr_i;
      res_data   = head_job_i.data;
      res_wen    = head_job_i.wen;
      res_status = head_job_i.status;
    end
    addr_ext                  = '0;
    addr_ext[ADDR_BITS-1:0]   = res_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      k_q         <= is_last ? '0 : k_q + KW'(1);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q   <= addr_ext[OUT_ADDR_W-1:0];
      data_q   <= res_data;
      wen_q    <= res_wen;
      status_q <= res_status;
      last_q   <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign write_addr_o = addr_q;
  assign write_data_o = data_q;
  assign write_en_o   = wen_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  `NTS_ASSERT(a_mid_header, k_q != '0 |-> !q_empty_i && head_job_i.hdr)
  `NTS_ASSERT(a_last_pending, out_valid_q && !last_q |-> k_q != '0)
  `NTS_ASSERT_NR(a_reset_idle, !rst_ni |=> !out_valid_q)

endmodule

[rtl/core/nested_tlv_serializer.sv]
// Top level of the nested TLV serializer: config register, front, queue, back.
// Depends on nts_pkg, nts_front, nts_fifo and nts_back.
//
//   channel  dir  handshake                  word
//   in       in   in_valid_i / in_ready_o    mode, item_id, item_len, data_byte
//   out      out  out_valid_o / out_ready_i  write_addr, write_data, write_en, status, last
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_data_i (start_offset)
//
// A command word is taken in any cycle the job queue has room, and its stack and
// offset update completes in that cycle; in_ready_o drops only while the queue is full.
// The back end sends one write word per cycle while the queue is not empty and out_ready_i
// allows: one for most commands, HEADER_BYTES for a header, so header bursts set the sustained rate.
// A command's job passes through the job queue and the output register before its first write word is offered.
// Reset clears level, offset, queue, output valid flag and start_offset; cfg is always ready.
module nested_tlv_serializer import nts_pkg::*; #(
  parameter int NEST_DEPTH   = 8,
  parameter int HEADER_BYTES = 4,
  parameter int ADDR_BITS    = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [ID_W-1:0]       item_id_i,
  input  logic [LEN_W-1:0]      item_len_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  // write words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_ADDR_W-1:0] write_addr_o,
  output logic [BYTE_W-1:0]     write_data_o,
  output logic                  write_en_o,
  output logic [1:0]            status_o,
  output logic                  last_o,
  // start offset register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int Q_W = $bits(job_t) + ADDR_BITS;

  logic [CFG_W-1:0]     start_offset_q;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  job_t                 front_job;
  logic [ADDR_BITS-1:0] front_addr;
  logic [Q_W-1:0]       q_rdata;
  job_t                 head_job;
  logic [ADDR_BITS-1:0] head_addr;

  // Write only while idle, so the register never changes under a command; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_offset_q <= cfg_data_i;
    end
  end

  nts_front #(
    .NEST_DEPTH  (NEST_DEPTH),
    .HEADER_BYTES(HEADER_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .item_id_i     (item_id_i),
    .item_len_i    (item_len_i),
    .data_byte_i   (data_byte_i),
    .start_offset_i(start_offset_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .job_o         (front_job),
    .job_addr_o    (front_addr)
  );

  // Absorb header bursts so the front end keeps taking data bytes.
  nts_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({front_job, front_addr}),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign head_job  = job_t'(q_rdata[Q_W-1:ADDR_BITS]);
  assign head_addr = q_rdata[ADDR_BITS-1:0];

  nts_back #(
    .HEADER_BYTES(HEADER_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .head_addr_i (head_addr),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .write_addr_o(write_addr_o),
    .write_data_o(write_data_o),
    .write_en_o  (write_en_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
